// File: hdl/lbp_pkg.sv
`default_nettype none
package lbp_pkg;

  // byte counter width (capacity, room, bytes written)
  localparam int unsigned COUNT_WIDTH = 24;
  // most bytes one append can complete
  localparam int unsigned BYTE_LANES  = 4;
  localparam int unsigned MAX_BITS    = 32;

  // item kinds
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [5:0]  bit_count;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   byte_valid;
    logic                   last;
    logic                   overflow_error;
    logic [COUNT_WIDTH-1:0] bytes_written;
  } out_word_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [8*BYTE_LANES-1:0] data;     // completed bytes, first in lane 0
    logic [2:0]              nbyte;    // bytes to emit
    logic                    tail;     // closing item without a byte
    logic                    err;      // tail reports overflow
    logic [COUNT_WIDTH-1:0]  written;  // count shown on the final item
  } job_t;

endpackage
`default_nettype wire

// File: hdl/lbp_front.sv
`default_nettype none
module lbp_front import lbp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire in_word_t               in_word_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [COUNT_WIDTH-1:0] cfg_data_i,
  output logic                        job_push_o,
  output job_t                        job_o
);

  logic [2:0]             fill_q, fill_d;
  logic [7:0]             pending_q, pending_d;
  logic [COUNT_WIDTH-1:0] room_q, room_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;

  logic [5:0]  nbits;
  logic [31:0] val_m;
  logic [39:0] merged;
  logic [5:0]  tot_bits;
  logic [2:0]  nfull;
  logic        ovf;
  logic [7:0]  left_byte;

  // saturate count, mask unused value bits, merge above pending bits
  always_comb begin
    nbits = (in_word_i.bit_count > 6'(MAX_BITS)) ? 6'(MAX_BITS) : in_word_i.bit_count;
    for (int i = 0; i < 32; i++) begin
      val_m[i] = in_word_i.value[i] & (6'(i) < nbits);
    end
    merged   = ({8'b0, val_m} << fill_q) | {32'b0, pending_q};
    tot_bits = {3'b0, fill_q} + nbits;
    nfull    = tot_bits[5:3];
    ovf      = {{(COUNT_WIDTH-3){1'b0}}, nfull} > room_q;
  end

  // leftover partial byte after the completed ones
  always_comb begin
    unique case (nfull)
      3'd0:    left_byte = merged[7:0];
      3'd1:    left_byte = merged[15:8];
      3'd2:    left_byte = merged[23:16];
      3'd3:    left_byte = merged[31:24];
      3'd4:    left_byte = merged[39:32];
      default: left_byte = 8'h00;
    endcase
  end

  // classify the item and update packer state
  always_comb begin
    fill_d     = fill_q;
    pending_d  = pending_q;
    room_d     = room_q;
    total_d    = total_q;
    job_push_o = 1'b0;
    job_o      = '0;
    if (cfg_we_i) begin
      fill_d    = '0;
      pending_d = '0;
      room_d    = cfg_data_i;
      total_d   = '0;
    end else if (accept_i) begin
      if (in_word_i.mode == MODE_APPEND) begin
        job_o.data = merged[31:0];
        if (ovf) begin
          job_push_o  = 1'b1;
          job_o.nbyte = room_q[2:0];
          job_o.tail  = 1'b1;
          job_o.err   = 1'b1;
          fill_d      = '0;
          pending_d   = '0;
          room_d      = '0;
          total_d     = '0;
        end else begin
          job_push_o  = (nfull != 3'd0);
          job_o.nbyte = nfull;
          fill_d      = tot_bits[2:0];
          pending_d   = left_byte;
          room_d      = room_q - COUNT_WIDTH'(nfull);
          total_d     = total_q + COUNT_WIDTH'(nfull);
        end
      end else begin
        job_push_o = 1'b1;
        if (fill_q == 3'd0) begin
          job_o.tail    = 1'b1;
          job_o.written = total_q;
        end else if (room_q == '0) begin
          job_o.tail = 1'b1;
          job_o.err  = 1'b1;
          fill_d     = '0;
          pending_d  = '0;
          total_d    = '0;
        end else begin
          job_o.data    = {24'b0, pending_q};
          job_o.nbyte   = 3'd1;
          job_o.written = total_q + COUNT_WIDTH'(1);
          fill_d        = '0;
          pending_d     = '0;
          room_d        = room_q - COUNT_WIDTH'(1);
          total_d       = total_q + COUNT_WIDTH'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      pending_q <= '0;
      room_q    <= '0;
      total_q   <= '0;
    end else begin
      fill_q    <= fill_d;
      pending_q <= pending_d;
      room_q    <= room_d;
      total_q   <= total_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lbp_queue.sv
`default_nettype none
module lbp_queue import lbp_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and occupancy update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lbp_back.sv
`default_nettype none
module lbp_back import lbp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire job_t q_job_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output out_word_t out_word_o
);

  logic       busy_q, busy_d;
  logic [2:0] idx_q, idx_d;
  job_t       job_q;
  logic [2:0] n_items;
  logic       is_byte, last_item, load;

  assign n_items   = job_q.nbyte + {2'b0, job_q.tail};
  assign is_byte   = idx_q < job_q.nbyte;
  assign last_item = (idx_q == n_items - 3'd1);
  assign empty_o   = !busy_q;
  assign load      = q_valid_i && (!busy_q || (pop_i && last_item));
  assign q_pop_o   = load;

  // current result word
  always_comb begin
    out_word_o                = '0;
    out_word_o.byte_valid     = is_byte;
    out_word_o.last           = last_item;
    out_word_o.overflow_error = !is_byte && job_q.err;
    out_word_o.bytes_written  = last_item ? job_q.written : '0;
    if (is_byte) begin
      out_word_o.out_byte = job_q.data[8*idx_q[1:0] +: 8];
    end
  end

  // step through the words of the held job
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && pop_i) begin
      if (last_item) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= q_job_i;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lsb_first_bit_packer.sv
// Channel   Direction  Handshake                 Word
// input     in         push / full               in_word_i  (mode, bit_count, value)
// result    out        empty / pop               out_word_o (byte, flags, bytes_written)
// capacity  in         cfg_valid_i / cfg_ready_o cfg_data_i (24-bit byte capacity)
//
// An input word is classified in the cycle it is accepted and queued for the
// back end; its first result word shows once the back end loads it from the queue.
// The back end shows one result word per cycle while pop is asserted; an item
// has 0 to 4 result words, and the input can take new items while older ones wait.
// Reset clears all control state and leaves zero capacity; no clearing pass follows.
// full rises only when the job queue is full; results may stall indefinitely.
`default_nettype none
module lsb_first_bit_packer import lbp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push,
  output logic                        full,
  input  wire in_word_t               in_word_i,
  output logic                        empty,
  input  wire logic                   pop,
  output out_word_t                   out_word_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [COUNT_WIDTH-1:0] cfg_data_i
);

  logic job_push, q_pop, q_valid;
  job_t job_in, job_head;

  assign cfg_ready_o = 1'b1;

  lbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (push && !full),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  lbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (job_head)
  );

  lbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (job_head),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_word_o (out_word_o)
  );

endmodule
`default_nettype wire

// File: hdl/lbp_checker.sv
`default_nettype none
module lbp_checker import lbp_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_word_t out_word_o
);

  // a waiting word holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_word_o)))
    else $error("result word changed while stalled");

  // a word without a byte always closes its item
  a_nobyte_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_word_o.byte_valid) |-> out_word_o.last)
    else $error("byteless word not marked last");

  // overflow words carry no byte and no count
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.overflow_error) |->
      (!out_word_o.byte_valid && out_word_o.bytes_written == '0 && out_word_o.out_byte == 8'h00))
    else $error("overflow word carries data");

  // words inside an item carry no count
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_word_o.last) |-> (out_word_o.bytes_written == '0))
    else $error("count shown before final word");

endmodule

bind lsb_first_bit_packer lbp_checker u_lbp_checker (.*);
`default_nettype wire
